### rtl/diir_pkg.sv
package diir_pkg;

  // Fixed formats of the coefficient registers and the default filter shape
  localparam int COEF_BITS           = 24;
  localparam int MAX_TAPS            = 3;
  localparam int DEFAULT_ORDER       = 3;
  localparam int DEFAULT_SAMPLE_BITS = 16;
  localparam int DEFAULT_COEF_FRAC   = 20;

  localparam int CFG_INDEX_BITS = 3;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  // Register map
  localparam cfg_index_t REG_FEED_COEF_0 = 3'd0;
  localparam cfg_index_t REG_FEED_COEF_1 = 3'd1;
  localparam cfg_index_t REG_FEED_COEF_2 = 3'd2;
  localparam cfg_index_t REG_FEED_COEF_3 = 3'd3;
  localparam cfg_index_t REG_BACK_COEF_1 = 3'd4;
  localparam cfg_index_t REG_BACK_COEF_2 = 3'd5;
  localparam cfg_index_t REG_BACK_COEF_3 = 3'd6;

endpackage

### rtl/direct_form_iir_filter.sv
// A sample taken into the input register moves on to the result register and out_valid.
// One sample per cycle while out_stall does not hold the result; the feedback closes through the
//   multiply-accumulate of all taps feeding the output history register.
// Reset (rst, synchronous): delay lines clear to zero, feed_coef_0 returns to 1.0,
//   all other coefficients to 0, and both pipeline stages empty.
module direct_form_iir_filter #(
  parameter int ORDER          = diir_pkg::DEFAULT_ORDER,
  parameter int SAMPLE_BITS    = diir_pkg::DEFAULT_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = diir_pkg::DEFAULT_COEF_FRAC
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          clipped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  diir_pkg::cfg_index_t          cfg_index,
  input  diir_pkg::coef_t               cfg_data
);

  import diir_pkg::*;

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int RND_W  = ACC_W + 1;

  localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [RND_W-1:0] SAT_HI     = RND_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [RND_W-1:0] SAT_LO     = -SAT_HI - RND_W'(1);
  localparam coef_t                   COEF_ONE   = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

  coef_t feed_coef [0:MAX_TAPS];
  coef_t back_coef [1:MAX_TAPS];

  logic signed [SAMPLE_BITS-1:0] in_hist  [0:ORDER-1];
  logic signed [SAMPLE_BITS-1:0] out_hist [0:ORDER-1];

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_advance;

  logic signed [PROD_W-1:0]      prod_ff [0:ORDER];
  logic signed [PROD_W-1:0]      prod_fb [0:ORDER-1];
  logic signed [ACC_W-1:0]       acc;
  logic signed [RND_W-1:0]       rnd;
  logic signed [SAMPLE_BITS-1:0] y_next;
  logic                          clip_next;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_coef[0] <= COEF_ONE;
      for (int k = 1; k <= MAX_TAPS; k++) begin
        feed_coef[k] <= '0;
        back_coef[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FEED_COEF_0: feed_coef[0] <= cfg_data;
        REG_FEED_COEF_1: feed_coef[1] <= cfg_data;
        REG_FEED_COEF_2: feed_coef[2] <= cfg_data;
        REG_FEED_COEF_3: feed_coef[3] <= cfg_data;
        REG_BACK_COEF_1: back_coef[1] <= cfg_data;
        REG_BACK_COEF_2: back_coef[2] <= cfg_data;
        REG_BACK_COEF_3: back_coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: take a new sample whenever the slot is empty or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample_in;
    end
  end

  always_comb begin
    prod_ff[0] = feed_coef[0] * s1_sample;
    for (int k = 0; k < ORDER; k++) begin
      prod_ff[k+1] = feed_coef[k+1] * in_hist[k];
      prod_fb[k]   = back_coef[k+1] * out_hist[k];
    end
    acc = ACC_W'(prod_ff[0]);
    for (int k = 0; k < ORDER; k++) begin
      acc = acc + ACC_W'(prod_ff[k+1]) - ACC_W'(prod_fb[k]);
    end
    // round half up, then clamp to the sample range
    rnd = (RND_W'(acc) + ROUND_HALF) >>> COEF_FRAC_BITS;
    if (rnd > SAT_HI) begin
      y_next    = SAMPLE_BITS'(SAT_HI);
      clip_next = 1'b1;
    end else if (rnd < SAT_LO) begin
      y_next    = SAMPLE_BITS'(SAT_LO);
      clip_next = 1'b1;
    end else begin
      y_next    = SAMPLE_BITS'(rnd);
      clip_next = 1'b0;
    end
  end

  // Delay lines advance together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ORDER; k++) begin
        in_hist[k]  <= '0;
        out_hist[k] <= '0;
      end
    end else if (s1_advance) begin
      for (int k = ORDER - 1; k > 0; k--) begin
        in_hist[k]  <= in_hist[k-1];
        out_hist[k] <= out_hist[k-1];
      end
      in_hist[0]  <= s1_sample;
      out_hist[0] <= y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      sample_out <= y_next;
      clipped    <= clip_next;
    end
  end

endmodule
